// File: rtl/rdfl_pkg.sv
// Shared constants, types and helpers of the RK4 decay fit likelihood block.
`default_nettype none

package rdfl_pkg;

  // Field and register widths
  localparam int AMOUNT_W    = 32;
  localparam int FIELD_W     = 32;
  localparam int SCORE_W     = 64;
  localparam int K_W         = 18;
  localparam int DT_W        = 16;
  localparam int STEPS_W     = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Internal datapath widths
  localparam int WIDE_W    = 42;             // RK4 intermediates and increment sum
  localparam int ERR_W     = FIELD_W + 1;    // measured minus simulated
  localparam int MUL_A_W   = 38;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 18;

  // Divide-by-six unit: bits resolved per cycle and cycle count
  localparam int DIV_STEP   = 7;
  localparam int DIV_CYCLES = WIDE_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int DIV_REM_W  = 3;
  localparam logic [DIV_REM_W:0] DIVISOR = (DIV_REM_W + 1)'(6);
  localparam logic [WIDE_W-1:0] DIV_ROUND = WIDE_W'(3);

  // Rounding constant for the Q16 products
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_BITS - 1));

  // Largest error whose square still fits below the score range
  localparam logic [ERR_W-1:0] SQRT_LIMIT = ERR_W'(64'd3037000499);

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  localparam logic [DT_W-1:0]    TIME_STEP_RESET = DT_W'(655);
  localparam logic [STEPS_W-1:0] STEPS_RESET     = STEPS_W'(50);

  localparam logic signed [WIDE_W-1:0] AMT_HI =
    {{(WIDE_W-AMOUNT_W+1){1'b0}}, {(AMOUNT_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] AMT_LO =
    {{(WIDE_W-AMOUNT_W+1){1'b1}}, {(AMOUNT_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INIT_FIRST  = 3'd0,
    CFG_INIT_SECOND = 3'd1,
    CFG_RATE_K      = 3'd2,
    CFG_TIME_STEP   = 3'd3,
    CFG_STEPS       = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_CGET,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_ERR,
    ST_SCORE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_K1,
    PH_K2,
    PH_K3,
    PH_K4
  } rk_phase_t;

  // Clamp a wide intermediate to the signed amount range
  function automatic logic signed [AMOUNT_W-1:0] sat_amount(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [AMOUNT_W-1:0] r;
    if (v > AMT_HI) begin
      r = AMT_HI[AMOUNT_W-1:0];
    end else if (v < AMT_LO) begin
      r = AMT_LO[AMOUNT_W-1:0];
    end else begin
      r = v[AMOUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rdfl_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module rdfl_mul import rdfl_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  product
);

  // Capture the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      product <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire

// File: rtl/rdfl_div6.sv
// Iterative divide by six, rounding to nearest with halves away from zero.
`default_nettype none

module rdfl_div6 import rdfl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [WIDE_W-1:0] value,
  output logic                     done,
  output logic signed [WIDE_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WIDE_W-1:0]    work;
  logic [DIV_REM_W-1:0] rem;
  logic                 neg;

  logic [WIDE_W-1:0]    work_next;
  logic [DIV_REM_W-1:0] rem_next;
  logic [WIDE_W-1:0]    mag;

  assign mag = value[WIDE_W-1] ? (WIDE_W'(0) - value) : value;

  // Resolve DIV_STEP quotient bits of the long division
  always_comb begin
    logic [WIDE_W-1:0]    w;
    logic [DIV_REM_W-1:0] r;
    logic [DIV_REM_W:0]   t;
    w = work;
    r = rem;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, w[WIDE_W-1]};
      w = {w[WIDE_W-2:0], 1'b0};
      if (t >= DIVISOR) begin
        t    = t - DIVISOR;
        w[0] = 1'b1;
      end
      r = t[DIV_REM_W-1:0];
    end
    work_next = w;
    rem_next  = r;
  end

  // Control: load on start, count digit groups, flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude plus three, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= value[WIDE_W-1];
      work <= mag + DIV_ROUND;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  // Restore the sign
  assign quotient = neg ? (WIDE_W'(0) - work) : work;

endmodule

`default_nettype wire

// File: rtl/rk4_decay_fit_likelihood.sv
// Top level: sequencer, state and score datapath of the RK4 decay fit block.
//
// Usage: write the five registers on the cfg port (cfg_write, cfg_index,
// cfg_data) while the block is idle, then stream measured samples on the
// in channel (in_valid/in_ready). Each input transaction yields one result
// transaction on the out channel (out_valid/out_ready) carrying both
// simulated amounts, the running score and run_done.
// The first sample of a run loads the initial amounts and is scored
// against them with no RK4 step. Every later sample runs steps_per_sample
// RK4 steps; each step makes four passes through the shared multiplier,
// then one pass through the divide-by-six unit.
// in_ready is high only in the idle state; an item can be taken while the
// previous result still waits in the output register. If the receiver
// stalls, the finished result waits in the output stage and the next
// item holds until that register frees.
// Reset clears the state, the score and the run flag, restores the
// register defaults and leaves the output register empty.
`default_nettype none

module rk4_decay_fit_likelihood import rdfl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FIELD_W-1:0]   measured_value,
  input  logic                        last_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FIELD_W-1:0]   simulated_first,
  output logic signed [FIELD_W-1:0]   simulated_second,
  output logic signed [SCORE_W-1:0]   score_so_far,
  output logic                        run_done
);

  // Configuration registers
  logic signed [FIELD_W-1:0] init_first;
  logic signed [FIELD_W-1:0] init_second;
  logic [K_W-1:0]            rate_k;
  logic [DT_W-1:0]           time_step;
  logic [STEPS_W-1:0]        steps_per_sample;

  // Sequencer and model state
  state_t                     state, state_next;
  rk_phase_t                  phase, phase_next;
  logic                       run_started, run_started_next;
  logic signed [AMOUNT_W-1:0] amount_first, amount_first_next;
  logic signed [AMOUNT_W-1:0] amount_second, amount_second_next;
  logic signed [SCORE_W-1:0]  score_sum, score_sum_next;
  logic [STEPS_W-1:0]         step_cnt, step_cnt_next;
  logic [COEF_W-1:0]          coef, coef_next;
  logic signed [WIDE_W-1:0]   y_val, y_val_next;
  logic signed [WIDE_W-1:0]   sum, sum_next;
  logic signed [FIELD_W-1:0]  meas, meas_next;
  logic                       last, last_next;
  logic                       sq_sat, sq_sat_next;

  // Output register
  logic                       out_load;
  logic signed [FIELD_W-1:0]  out_first;
  logic signed [FIELD_W-1:0]  out_second;
  logic signed [SCORE_W-1:0]  out_score;
  logic                       out_last;

  // Shared units
  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   product;
  logic                       div_start;
  logic                       div_done;
  logic signed [WIDE_W-1:0]   quotient;

  // Datapath terms
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [WIDE_W-1:0]   d_val;
  logic signed [WIDE_W-1:0]   d_half;
  logic signed [WIDE_W-1:0]   d_add;
  logic signed [WIDE_W-1:0]   sum_acc;
  logic signed [WIDE_W-1:0]   x_ext;
  logic signed [WIDE_W-1:0]   s2_ext;
  logic signed [AMOUNT_W-1:0] x_new;
  logic signed [ERR_W-1:0]    err_val;
  logic [ERR_W-1:0]           err_mag;
  logic [SCORE_W-1:0]         sq_val;
  logic signed [SCORE_W:0]    score_diff;

  rdfl_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  rdfl_div6 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .value    (sum_acc),
    .done     (div_done),
    .quotient (quotient)
  );

  // Round the registered product back to Q16
  assign prod_rnd = product + ROUND_HALF;
  assign d_val    = prod_rnd[FRAC_BITS +: WIDE_W];
  assign d_half   = d_val >>> 1;
  assign d_add    = (phase == PH_K2 || phase == PH_K3) ? (d_val <<< 1) : d_val;
  assign sum_acc  = sum + d_add;

  assign x_ext  = {{(WIDE_W-AMOUNT_W){amount_first[AMOUNT_W-1]}}, amount_first};
  assign s2_ext = {{(WIDE_W-AMOUNT_W){amount_second[AMOUNT_W-1]}}, amount_second};
  assign x_new  = sat_amount(x_ext - quotient);

  // Error against the measurement and its magnitude
  assign err_val = {meas[FIELD_W-1], meas}
                 - {{(ERR_W-AMOUNT_W){amount_first[AMOUNT_W-1]}}, amount_first};
  assign err_mag = err_val[ERR_W-1] ? (ERR_W'(0) - err_val) : err_val;

  // Saturating score update
  assign sq_val     = sq_sat ? SCORE_MAX : product[SCORE_W-1:0];
  assign score_diff = {score_sum[SCORE_W-1], score_sum} - {1'b0, sq_val};

  assign in_ready = (state == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_first       <= '0;
      init_second      <= '0;
      rate_k           <= '0;
      time_step        <= TIME_STEP_RESET;
      steps_per_sample <= STEPS_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_INIT_FIRST:  init_first       <= cfg_data[FIELD_W-1:0];
        CFG_INIT_SECOND: init_second      <= cfg_data[FIELD_W-1:0];
        CFG_RATE_K:      rate_k           <= cfg_data[K_W-1:0];
        CFG_TIME_STEP:   time_step        <= cfg_data[DT_W-1:0];
        CFG_STEPS:       steps_per_sample <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // State register and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      run_started   <= 1'b0;
      amount_first  <= '0;
      amount_second <= '0;
      score_sum     <= '0;
    end else begin
      state         <= state_next;
      run_started   <= run_started_next;
      amount_first  <= amount_first_next;
      amount_second <= amount_second_next;
      score_sum     <= score_sum_next;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    phase    <= phase_next;
    step_cnt <= step_cnt_next;
    coef     <= coef_next;
    y_val    <= y_val_next;
    sum      <= sum_next;
    meas     <= meas_next;
    last     <= last_next;
    sq_sat   <= sq_sat_next;
  end

  // Output register: hold until taken, reload when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first  <= amount_first;
      out_second <= amount_second;
      out_score  <= score_sum;
      out_last   <= last;
    end
  end

  assign simulated_first  = out_first;
  assign simulated_second = out_second;
  assign score_so_far     = out_score;
  assign run_done         = out_last;

  // Sequencer: next state, unit controls and register updates
  always_comb begin
    state_next         = state;
    phase_next         = phase;
    run_started_next   = run_started;
    amount_first_next  = amount_first;
    amount_second_next = amount_second;
    score_sum_next     = score_sum;
    step_cnt_next      = step_cnt;
    coef_next          = coef;
    y_val_next         = y_val;
    sum_next           = sum;
    meas_next          = meas;
    last_next          = last;
    sq_sat_next        = sq_sat;
    mul_en             = 1'b0;
    mul_a              = '0;
    mul_b              = '0;
    div_start          = 1'b0;
    out_load           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          meas_next     = measured_value;
          last_next     = last_sample;
          step_cnt_next = steps_per_sample;
          if (!run_started) begin
            // Run start: load initial amounts, clear the score
            amount_first_next  = init_first;
            amount_second_next = init_second;
            score_sum_next     = '0;
            run_started_next   = 1'b1;
            state_next         = ST_ERR;
          end else begin
            state_next = ST_COEF;
          end
        end
      end

      ST_COEF: begin
        // Issue k * dt
        mul_en     = 1'b1;
        mul_a      = {{(MUL_A_W-K_W){1'b0}}, rate_k};
        mul_b      = {{(MUL_B_W-DT_W){1'b0}}, time_step};
        state_next = ST_CGET;
      end

      ST_CGET: begin
        coef_next  = prod_rnd[FRAC_BITS +: COEF_W];
        y_val_next = x_ext;
        sum_next   = '0;
        phase_next = PH_K1;
        if (step_cnt == '0) begin
          state_next = ST_ERR;
        end else begin
          state_next = ST_MUL;
        end
      end

      ST_MUL: begin
        // Issue y * c for the current stage
        mul_en     = 1'b1;
        mul_a      = y_val[MUL_A_W-1:0];
        mul_b      = {{(MUL_B_W-COEF_W){1'b0}}, coef};
        state_next = ST_ACC;
      end

      ST_ACC: begin
        // Accumulate the stage increment and form the next stage argument
        sum_next = sum_acc;
        case (phase)
          PH_K1: begin
            y_val_next = x_ext - d_half;
            phase_next = PH_K2;
            state_next = ST_MUL;
          end
          PH_K2: begin
            y_val_next = x_ext - d_half;
            phase_next = PH_K3;
            state_next = ST_MUL;
          end
          PH_K3: begin
            y_val_next = x_ext - d_val;
            phase_next = PH_K4;
            state_next = ST_MUL;
          end
          PH_K4: begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_DIV: begin
        if (div_done) begin
          // Apply the averaged increment and advance the step count
          amount_first_next  = x_new;
          amount_second_next = sat_amount(s2_ext + quotient);
          y_val_next         = {{(WIDE_W-AMOUNT_W){x_new[AMOUNT_W-1]}}, x_new};
          sum_next           = '0;
          phase_next         = PH_K1;
          step_cnt_next      = step_cnt - 1'b1;
          if (step_cnt == STEPS_W'(1)) begin
            state_next = ST_ERR;
          end else begin
            state_next = ST_MUL;
          end
        end
      end

      ST_ERR: begin
        // Square the error and flag it when its square is beyond the score range
        sq_sat_next = (err_mag > SQRT_LIMIT);
        mul_en      = 1'b1;
        mul_a       = {{(MUL_A_W-ERR_W){1'b0}}, err_mag};
        mul_b       = err_mag;
        state_next  = ST_SCORE;
      end

      ST_SCORE: begin
        if (score_diff[SCORE_W] != score_diff[SCORE_W-1]) begin
          score_sum_next = SCORE_MIN;
        end else begin
          score_sum_next = score_diff[SCORE_W-1:0];
        end
        state_next = ST_OUT;
      end

      ST_OUT: begin
        // Hand the result to the output register once it is free
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (last) begin
            run_started_next = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
